// ===== rtl/core/heat_equation_explicit_stencil_macros.svh =====
// Assertion macros for the heat equation stencil block.
`ifndef HEAT_EQUATION_EXPLICIT_STENCIL_MACROS_SVH
`define HEAT_EQUATION_EXPLICIT_STENCIL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heq assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heq assertion failed");

`else

`define HEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/heq_pkg.sv =====
// Shared constants, types and codes of the heat equation stencil block.
`timescale 1ns / 1ps

package heq_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int MIN_POINTS  = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int LEN_W       = $clog2(MAX_POINTS + 1);
    localparam int COEF_W      = 16;
    localparam int STEP_W      = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int KIND_W      = 2;
    localparam int FRAC_BITS   = 16;
    localparam int LAP_W       = VALUE_WIDTH + 2;
    localparam int PROD_W      = LAP_W + COEF_W + 1;
    localparam int TERM_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W       = TERM_W + 1;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   hit;
        logic   changed;
    } t_unit_res;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF   = 2'd0,
        CFG_STEPS  = 2'd1,
        CFG_POINTS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RUN_INIT,
        ST_RUN_L,
        ST_RUN_C,
        ST_RUN_R,
        ST_RUN_MUL,
        ST_RUN_WB
    } t_state;

endpackage

// ===== rtl/core/heat_equation_explicit_stencil.sv =====
// Top level of the 1D explicit heat equation stencil block with its sequencer.
// A load item is written and ready stays high; a read waits in ST_RD_WAIT for a free output.
// A run item walks ST_RUN_INIT, ST_RUN_L, ST_RUN_C per time step and ST_RUN_R, ST_RUN_MUL,
// ST_RUN_WB per interior point, due to the single shared update unit and one grid read port.
// A run ends early after a step in which no point changed; input ready stays low meanwhile.
// Synchronous active-low reset clears pointers, flag and state, presets registers; no clearing pass.
`timescale 1ns / 1ps
`include "heat_equation_explicit_stencil_macros.svh"

module heat_equation_explicit_stencil import heq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_WIDTH-1:0] s_axis_tdata,   // point_value
    input  logic [KIND_W-1:0]      s_axis_tuser,   // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VALUE_WIDTH-1:0] m_axis_tdata,   // result_value
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser    // saturated
);

    t_state             r_state, n_state;
    logic [COEF_W-1:0]  r_coef;
    logic [STEP_W-1:0]  r_steps_cfg;
    logic [LEN_W-1:0]   r_points;
    logic [ADDR_W-1:0]  r_ld_ptr, n_ld_ptr;
    logic [ADDR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [ADDR_W-1:0]  r_rd_p, n_rd_p;
    logic               r_rd_last, n_rd_last;
    logic               r_sat, n_sat;
    logic [ADDR_W-1:0]  r_m, n_m;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_changed, n_changed;
    t_value             r_left, n_left;
    t_value             r_center, n_center;
    logic               r_out_valid, n_out_valid;
    t_value             r_out_data, n_out_data;
    logic               r_out_last, n_out_last;
    logic               r_out_sat, n_out_sat;

    logic [LEN_W-1:0]   w_n;
    logic [ADDR_W-1:0]  w_ld_p;
    logic [ADDR_W-1:0]  w_rd_p;
    logic [LEN_W-1:0]   w_ld_inc;
    logic [LEN_W-1:0]   w_rd_inc;
    logic               w_accept;
    logic               w_out_free;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_value             w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    t_value             w_rdata;
    t_unit_res          w_res;
    logic               w_ch;
    logic [STEP_W-1:0]  w_step_inc;

    heq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_POINTS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    heq_unit u_unit (
        .i_clk    (i_clk),
        .i_left   (r_left),
        .i_center (r_center),
        .i_right  (w_rdata),
        .i_coef   (r_coef),
        .o_res    (w_res)
    );

    always_comb begin
        if (r_points < LEN_W'(MIN_POINTS)) begin
            w_n = LEN_W'(MIN_POINTS);
        end else if (r_points > LEN_W'(MAX_POINTS)) begin
            w_n = LEN_W'(MAX_POINTS);
        end else begin
            w_n = r_points;
        end
    end

    assign w_ld_p     = (LEN_W'(r_ld_ptr) < w_n) ? r_ld_ptr : '0;
    assign w_rd_p     = (LEN_W'(r_rd_ptr) < w_n) ? r_rd_ptr : '0;
    assign w_ld_inc   = LEN_W'(w_ld_p) + LEN_W'(1);
    assign w_rd_inc   = LEN_W'(w_rd_p) + LEN_W'(1);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_ch       = r_changed || w_res.changed;
    assign w_step_inc = r_step + STEP_W'(1);

    always_comb begin
        n_state     = r_state;
        n_ld_ptr    = r_ld_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_rd_p      = r_rd_p;
        n_rd_last   = r_rd_last;
        n_sat       = r_sat;
        n_m         = r_m;
        n_step      = r_step;
        n_changed   = r_changed;
        n_left      = r_left;
        n_center    = r_center;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_sat   = r_out_sat;
        w_we        = 1'b0;
        w_waddr     = w_ld_p;
        w_wdata     = s_axis_tdata;
        w_raddr     = ADDR_W'(LEN_W'(r_m) + LEN_W'(1));

        case (r_state)
            ST_IDLE: begin
                w_raddr = w_rd_p;
                if (w_accept) begin
                    case (t_kind'(s_axis_tuser))
                        KIND_LOAD: begin
                            w_we = 1'b1;
                            if (w_ld_p == '0) begin
                                n_sat = 1'b0;
                            end
                            n_ld_ptr = (w_ld_inc < w_n) ? w_ld_inc[ADDR_W-1:0] : '0;
                        end
                        KIND_RUN: begin
                            n_step = '0;
                            if (r_steps_cfg != '0) begin
                                n_state = ST_RUN_INIT;
                            end
                        end
                        KIND_READ: begin
                            n_rd_p    = w_rd_p;
                            n_rd_last = (w_rd_inc == w_n);
                            n_rd_ptr  = (w_rd_inc < w_n) ? w_rd_inc[ADDR_W-1:0] : '0;
                            n_state   = ST_RD_WAIT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                w_raddr = r_rd_p;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_rdata;
                    n_out_last  = r_rd_last;
                    n_out_sat   = r_sat;
                    n_state     = ST_IDLE;
                end
            end
            ST_RUN_INIT: begin
                w_raddr   = '0;
                n_m       = ADDR_W'(1);
                n_changed = 1'b0;
                n_state   = ST_RUN_L;
            end
            ST_RUN_L: begin
                w_raddr = ADDR_W'(1);
                n_left  = w_rdata;
                n_state = ST_RUN_C;
            end
            ST_RUN_C: begin
                n_center = w_rdata;
                n_state  = ST_RUN_R;
            end
            ST_RUN_R: begin
                n_left   = r_center;
                n_center = w_rdata;
                n_state  = ST_RUN_MUL;
            end
            ST_RUN_MUL: begin
                n_state = ST_RUN_WB;
            end
            ST_RUN_WB: begin
                w_we      = 1'b1;
                w_waddr   = r_m;
                w_wdata   = w_res.value;
                w_raddr   = ADDR_W'(LEN_W'(r_m) + LEN_W'(2));
                n_sat     = r_sat || w_res.hit;
                n_changed = w_ch;
                if (LEN_W'(r_m) + LEN_W'(2) == w_n) begin
                    n_step = w_step_inc;
                    if (!w_ch || w_step_inc == r_steps_cfg) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RUN_INIT;
                    end
                end else begin
                    n_m     = r_m + ADDR_W'(1);
                    n_state = ST_RUN_R;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ld_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_coef      <= '0;
            r_steps_cfg <= STEP_W'(1);
            r_points    <= LEN_W'(MAX_POINTS);
        end else begin
            r_state     <= n_state;
            r_ld_ptr    <= n_ld_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_COEF:   r_coef      <= i_cfg_data[COEF_W-1:0];
                    CFG_STEPS:  r_steps_cfg <= i_cfg_data[STEP_W-1:0];
                    CFG_POINTS: r_points    <= i_cfg_data[LEN_W-1:0];
                    default:    r_coef      <= r_coef;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_p     <= n_rd_p;
        r_rd_last  <= n_rd_last;
        r_m        <= n_m;
        r_step     <= n_step;
        r_changed  <= n_changed;
        r_left     <= n_left;
        r_center   <= n_center;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_sat  <= n_out_sat;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_sat;

    `HEQ_ASSERT_IMP(a_wr_interior, i_clk, i_rst_n, w_we && (r_state != ST_IDLE), (w_waddr != '0) && ((LEN_W'(w_waddr) + LEN_W'(1)) < w_n))
    `HEQ_ASSERT_IMP(a_sat_rise, i_clk, i_rst_n, $rose(r_sat), $past(r_state == ST_RUN_WB))
    `HEQ_ASSERT_IMP(a_out_rise, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_RD_WAIT))
    `HEQ_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, w_accept && (s_axis_tuser == KIND_RUN) && (r_steps_cfg != '0), !s_axis_tready)

endmodule

// ===== rtl/core/heq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module heq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/heq_unit.sv =====
// Shared stencil update unit: Laplacian, coefficient product, then saturating add.
`timescale 1ns / 1ps

module heq_unit import heq_pkg::*; (
    input  logic              i_clk,
    input  t_value            i_left,
    input  t_value            i_center,
    input  t_value            i_right,
    input  logic [COEF_W-1:0] i_coef,
    output t_unit_res         o_res
);

    logic signed [LAP_W-1:0]  r_lap;
    t_value                   r_c1;
    logic signed [PROD_W-1:0] r_prod;
    t_value                   r_c2;

    logic signed [LAP_W-1:0]  w_l;
    logic signed [LAP_W-1:0]  w_c;
    logic signed [LAP_W-1:0]  w_r;
    logic signed [PROD_W-1:0] w_prod_sh;
    logic signed [TERM_W-1:0] w_term;
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-VALUE_WIDTH:0] w_top;
    logic                     w_hit;
    t_value                   w_value;

    assign w_l = LAP_W'(i_left);
    assign w_c = LAP_W'(i_center);
    assign w_r = LAP_W'(i_right);

    always_ff @(posedge i_clk) begin
        r_lap  <= w_l + w_r - (w_c <<< 1);
        r_c1   <= i_center;
        r_prod <= PROD_W'(r_lap) * $signed({1'b0, i_coef});
        r_c2   <= r_c1;
    end

    // An arithmetic shift drops the fraction bits and rounds toward minus infinity.
    assign w_prod_sh = r_prod >>> FRAC_BITS;
    assign w_term    = w_prod_sh[TERM_W-1:0];
    assign w_sum     = SUM_W'(r_c2) + SUM_W'(w_term);
    assign w_top     = w_sum[SUM_W-1:VALUE_WIDTH-1];
    assign w_hit     = (w_top != '0) && (w_top != '1);

    always_comb begin
        if (!w_hit) begin
            w_value = w_sum[VALUE_WIDTH-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            w_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
    end

    assign o_res.value   = w_value;
    assign o_res.hit     = w_hit;
    assign o_res.changed = (w_value != r_c2);

endmodule

// ===== tb/heat_equation_explicit_stencil_tb.sv =====
// Self-checking testbench of the 1D explicit heat equation stencil block.
`timescale 1ns / 1ps

module heat_equation_explicit_stencil_tb;
    import heq_pkg::*;

    localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
    localparam longint                 VAL_MAX     = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint                 VAL_MIN     = -VAL_MAX - 1;
    localparam logic [VALUE_WIDTH-1:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] Q_MIN       = 32'h8000_0000;
    localparam logic [VALUE_WIDTH-1:0] Q_ONE       = 32'h0100_0000;
    localparam int unsigned            COEF_HALF   = 32768;
    localparam int unsigned            COEF_MAX    = 65535;
    localparam int unsigned            STEPS_MAX   = 24'hFF_FFFF;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic                   sat;
    } t_readout;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [VALUE_WIDTH-1:0] s_axis_tdata;   // point_value
    logic [KIND_W-1:0]      s_axis_tuser;   // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [VALUE_WIDTH-1:0] m_axis_tdata;   // result_value
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;   // saturated

    // Shadow copy of the row, the pointers, the flag and the registers.
    longint      grid_mirror [MAX_POINTS];
    longint      next_mirror [MAX_POINTS];
    bit          written_mirror [MAX_POINTS];
    int unsigned load_at;
    int unsigned read_at;
    bit          sat_mirror;
    int unsigned coef_mirror;
    int unsigned steps_mirror;
    int unsigned points_mirror;
    int unsigned busy_cycles;

    t_readout    expected_readouts [$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned runs_sent;
    int unsigned readouts_checked;
    int unsigned rx_hold;
    bit          tx_burst;
    bit          rx_burst;

    heat_equation_explicit_stencil dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned row_len();
        if (points_mirror < MIN_POINTS) return MIN_POINTS;
        if (points_mirror > MAX_POINTS) return MAX_POINTS;
        return points_mirror;
    endfunction

    function automatic bit row_ready();
        int unsigned m;
        for (m = 0; m < row_len(); m++)
            if (!written_mirror[m]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value(input int unsigned mode);
        logic [VALUE_WIDTH-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // One Jacobi time step over the interior; returns whether any point moved.
    function automatic bit heat_step_mirror(input int unsigned n);
        int unsigned m;
        bit          changed;
        longint      lap;
        longint      v;
        changed = 1'b0;
        for (m = 1; m + 1 < n; m++) begin
            lap = grid_mirror[m-1] - 2 * grid_mirror[m] + grid_mirror[m+1];
            v = grid_mirror[m] + ((lap * longint'(coef_mirror)) >>> FRAC_BITS);
            if (v > VAL_MAX) begin
                v = VAL_MAX;
                sat_mirror = 1'b1;
            end else if (v < VAL_MIN) begin
                v = VAL_MIN;
                sat_mirror = 1'b1;
            end
            next_mirror[m] = v;
            if (v != grid_mirror[m]) changed = 1'b1;
        end
        for (m = 1; m + 1 < n; m++)
            grid_mirror[m] = next_mirror[m];
        return changed;
    endfunction

    task automatic update_grid_mirror(input logic [KIND_W-1:0] kind,
                                      input logic [VALUE_WIDTH-1:0] value);
        int unsigned n;
        int unsigned p;
        int unsigned s;
        t_readout    r;
        n = row_len();
        busy_cycles = 0;
        case (kind)
            KIND_LOAD: begin
                p = (load_at < n) ? load_at : 0;
                if (p == 0) sat_mirror = 1'b0;
                grid_mirror[p] = longint'($signed(value));
                written_mirror[p] = 1'b1;
                load_at = (p + 1 < n) ? p + 1 : 0;
            end
            KIND_RUN: begin
                s = 0;
                while (s < steps_mirror) begin
                    s++;
                    if (!heat_step_mirror(n)) break;
                end
                busy_cycles = s * (4 * n + 8) + 16;
                runs_sent++;
            end
            KIND_READ: begin
                p = (read_at < n) ? read_at : 0;
                r.value = grid_mirror[p][VALUE_WIDTH-1:0];
                r.last = (p + 1 == n);
                r.sat = sat_mirror;
                expected_readouts.push_back(r);
                read_at = (p + 1 < n) ? p + 1 : 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [VALUE_WIDTH-1:0] value);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        update_grid_mirror(kind, value);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COEF:   coef_mirror = data[COEF_W-1:0];
            CFG_STEPS:  steps_mirror = data[STEP_W-1:0];
            CFG_POINTS: points_mirror = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // A run gives no result, so after the last readout the block may still be stepping.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge i_clk);
        repeat (busy_cycles + 8) @(posedge i_clk);
        busy_cycles = 0;
    endtask

    task automatic fill_row(input int unsigned mode);
        repeat (row_len()) send_item(KIND_LOAD, pick_value(mode));
    endtask

    task automatic test_full_row();
        write_reg(CFG_POINTS, {11'($urandom_range(0, 2047)), 13'd600});
        fill_row(1);
        send_item(KIND_RUN, $urandom);
        wait_idle();
        write_reg(CFG_COEF, CFG_W'(COEF_HALF));
        send_item(KIND_RUN, $urandom);
        repeat (64) send_item(KIND_READ, $urandom);
        wait_idle();
    endtask

    task automatic test_saturation_flag();
        write_reg(CFG_POINTS, '0);
        write_reg(CFG_STEPS, CFG_W'(1));
        send_item(KIND_LOAD, Q_MAX);
        send_item(KIND_LOAD, Q_MIN);
        send_item(KIND_LOAD, Q_MAX);
        send_item(KIND_RUN, $urandom);
        repeat (3) send_item(KIND_READ, $urandom);
        wait_idle();
        write_reg(CFG_COEF, CFG_W'(COEF_MAX));
        send_item(KIND_LOAD, Q_MIN);
        send_item(KIND_LOAD, Q_MAX);
        send_item(KIND_LOAD, Q_MIN);
        send_item(KIND_RUN, $urandom);
        repeat (3) send_item(KIND_READ, $urandom);
        send_item(KIND_LOAD, Q_ONE);
        repeat (3) send_item(KIND_READ, $urandom);
        wait_idle();
    endtask

    task automatic test_step_extremes();
        write_reg(CFG_POINTS, CFG_W'(4));
        write_reg(CFG_STEPS, '0);
        repeat (4) send_item(KIND_LOAD, Q_ONE);
        send_item(KIND_RUN, $urandom);
        wait_idle();
        write_reg(CFG_STEPS, CFG_W'(STEPS_MAX));
        write_reg(CFG_COEF, CFG_W'(COEF_HALF));
        send_item(KIND_RUN, $urandom);
        send_item(KIND_UNUSED, $urandom);
        repeat (4) send_item(KIND_READ, $urandom);
        wait_idle();
        write_reg(CFG_POINTS, CFG_W'(2));
        repeat (2) send_item(KIND_READ, $urandom);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int unsigned target;
        int unsigned r;
        int unsigned mode;
        int unsigned pts;
        int unsigned coef;
        int unsigned steps;
        target = 1950;
        while (items_sent < target) begin
            wait_idle();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                pts = (r == 0) ? $urandom_range(0, 2) :
                      (r == 1) ? $urandom_range(33, 64) : $urandom_range(3, 16);
                write_reg(CFG_POINTS, {11'($urandom_range(0, 2047)), 13'(pts)});
            end
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                coef = (r == 0) ? 0 :
                       (r == 1) ? COEF_HALF :
                       (r == 2) ? $urandom_range(COEF_HALF + 1, COEF_MAX) :
                                  $urandom_range(0, COEF_HALF);
                write_reg(CFG_COEF, {8'($urandom_range(0, 255)), 16'(coef)});
            end
            r = $urandom_range(0, 9);
            steps = (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            write_reg(CFG_STEPS, 24'(steps));

            mode = $urandom_range(0, 2);
            if (!row_ready() || $urandom_range(0, 1)) fill_row(mode);
            send_item(KIND_RUN, $urandom);
            repeat (row_len()) send_item(KIND_READ, $urandom);
            repeat ($urandom_range(10, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 40) send_item(KIND_READ, $urandom);
                else if (r < 55) send_item(KIND_RUN, $urandom);
                else if (r < 95) send_item(KIND_LOAD, pick_value(mode));
                else send_item(KIND_UNUSED, $urandom);
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_readouts
        t_readout want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_hold <= rx_burst ? 0 : $urandom_range(0, 10);
            if (expected_readouts.size() == 0) begin
                $error("unexpected result item: result_value %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_readouts.pop_front();
                readouts_checked++;
                if (m_axis_tdata !== want.value) begin
                    $error("result_value mismatch: expected %h, got %h",
                           want.value, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_point mismatch: expected %b, got %b",
                           want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.sat) begin
                    $error("saturated mismatch: expected %b, got %b",
                           want.sat, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_COEF;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_LOAD;
        m_axis_tready = 1'b0;
        rx_hold = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        fail_count = 0;
        items_sent = 0;
        runs_sent = 0;
        readouts_checked = 0;
        load_at = 0;
        read_at = 0;
        sat_mirror = 1'b0;
        coef_mirror = 0;
        steps_mirror = 1;
        points_mirror = MAX_POINTS;
        busy_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_row();
        test_saturation_flag();
        test_step_extremes();
        test_random_phases();
        wait_idle();

        $display("Covered %0d load, run and read items including %0d runs, %0d readouts checked,",
                 items_sent, runs_sent, readouts_checked);
        $display("on rows of 3 to 600 points with coefficients from zero to the unstable maximum.");
        if (fail_count == 0) begin
            $display("heat_equation_explicit_stencil regression: pass");
        end else begin
            $display("heat_equation_explicit_stencil regression: fail");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("heat_equation_explicit_stencil regression: fail");
        $finish;
    end

endmodule

// ===== heat_equation_explicit_stencil.f =====
+incdir+rtl/core
rtl/core/heq_pkg.sv
rtl/core/heq_ram.sv
rtl/core/heq_unit.sv
rtl/core/heat_equation_explicit_stencil.sv
tb/heat_equation_explicit_stencil_tb.sv
